// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// Periodic column destriper package
// Shared constants and the control structs passed between the datapath and
// the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int PERIOD_BITS = 8;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd6;

  // four words cover a row-end pair landing on two words still waiting
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic row_last;
    logic burst_last;
  } pcd_flags_t;

  typedef struct packed {
    logic       one;      // push the first result word
    logic       two;      // push the second result word as well
    pcd_flags_t flags_a;
    pcd_flags_t flags_b;
  } pcd_push_t;

endpackage

`default_nettype wire

// File: rtl/pcd_if.sv
// ----------------------------------------------------------------------------
// Periodic column destriper channels
// Valid/ready pixel channels for the input and the result side.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   row_last_in;

  modport source (output valid, output sample_in, output row_last_in, input ready);
  modport sink   (input valid, input sample_in, input row_last_in, output ready);
endinterface

interface pcd_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   row_last_out;
  logic                   burst_last;

  modport source (output valid, output sample_out, output row_last_out,
                  output burst_last, input ready);
  modport sink   (input valid, input sample_out, input row_last_out,
                  input burst_last, output ready);
endinterface

`default_nettype wire

// File: rtl/pcd_out_queue.sv
// ----------------------------------------------------------------------------
// Destriper result queue
// Four-word shifting queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_out_queue #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pcd_pkg::pcd_push_t     push,
  input  wire logic [SAMPLE_BITS-1:0] data_a,
  input  wire logic [SAMPLE_BITS-1:0] data_b,
  output logic                        room,
  pcd_out_if.source                   pix_out
);
  import pcd_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_q [QUEUE_DEPTH];
  pcd_flags_t             flags_q  [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] sample_next [QUEUE_DEPTH];
  pcd_flags_t             flags_next  [QUEUE_DEPTH];
  logic [QCNT_BITS-1:0]   count;
  logic [QCNT_BITS-1:0]   count_next;
  logic [QCNT_BITS-1:0]   count_after;
  logic                   pop;

  assign pop  = pix_out.valid & pix_out.ready;
  assign room = count < QCNT_BITS'(QUEUE_DEPTH - 1);

  assign pix_out.valid        = count != '0;
  assign pix_out.sample_out   = sample_q[0];
  assign pix_out.row_last_out = flags_q[0].row_last;
  assign pix_out.burst_last   = flags_q[0].burst_last;

  always_comb begin
    count_after = count - QCNT_BITS'(pop);
    count_next  = count_after + QCNT_BITS'(push.one) + QCNT_BITS'(push.two);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sample_next[i] = sample_q[i];
      flags_next[i]  = flags_q[i];
    end
    // advance everything one place on a pop
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        sample_next[i] = sample_q[i+1];
        flags_next[i]  = flags_q[i+1];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push.one && (QCNT_BITS'(i) == count_after)) begin
        sample_next[i] = data_a;
        flags_next[i]  = push.flags_a;
      end
      if (push.two && (QCNT_BITS'(i) == count_after + QCNT_BITS'(1))) begin
        sample_next[i] = data_b;
        flags_next[i]  = push.flags_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sample_q[i] <= sample_next[i];
      flags_q[i]  <= flags_next[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/periodic_column_destriper_unit.sv
// Release: a pixel's word is written into the result queue when the pixel that
//   follows it in the row is taken; a row's last pixel releases the held word and itself.
// Throughput: one pixel per cycle while the output is ready; the four-word result queue
//   absorbs the two words of a row end, and input ready drops once three words wait in it.
// Reset (synchronous, active high): stripe period 6, no pixel held, queue empty.
// ----------------------------------------------------------------------------
// Periodic column destriper
// Replaces every period-th column by the mean of its two neighbours, with
// mirrored neighbours at row edges; one pixel of look-ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_column_destriper_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pcd_pkg::PERIOD_BITS-1:0] cfg_wdata,
  pcd_in_if.sink                               pix_in,
  pcd_out_if.source                            pix_out
);
  import pcd_pkg::*;

  // Configuration and control state
  logic [PERIOD_BITS-1:0] period;
  logic                   pend_valid;  // a pixel is held back
  logic                   pend_first;  // held pixel opens its row
  logic [PERIOD_BITS-1:0] phase;       // one-based column of held pixel mod period

  // Pixel window: held pixel and the one to its left
  logic [SAMPLE_BITS-1:0] pend_px;
  logic [SAMPLE_BITS-1:0] left_nb;

  logic                   accept;
  logic                   room;
  logic [SAMPLE_BITS-1:0] px;
  logic                   last;
  logic [SAMPLE_BITS-1:0] lft;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [SAMPLE_BITS-1:0] held_word;
  logic [SAMPLE_BITS-1:0] tail_word;
  logic [SAMPLE_BITS-1:0] data_a;
  logic [PERIOD_BITS-1:0] phase_step;  // phase after the held pixel
  logic [PERIOD_BITS-1:0] phase_inc;
  logic [PERIOD_BITS-1:0] phase_next;
  logic                   pend_valid_next;
  logic                   pend_first_next;
  pcd_push_t              push;

  assign accept       = pix_in.valid & pix_in.ready;
  assign pix_in.ready = room;
  assign px           = pix_in.sample_in;
  assign last         = pix_in.row_last_in;

  // Advance the column phase of the held pixel; wrap on reaching the period,
  // which also catches a period lowered in mid row. Period zero never wraps.
  always_comb begin
    phase_inc  = phase + PERIOD_BITS'(1);
    phase_step = phase_inc;
    if ((period != '0) && (phase_inc >= period)) begin
      phase_step = '0;
    end
  end

  // Held pixel: mean of neighbours if on a stripe, mirrored at the row start.
  // Row's last pixel: on a stripe its right neighbour mirrors the held one, so the mean
  // is just the held pixel; off a stripe the pixel passes through.
  always_comb begin
    lft       = pend_first ? px : left_nb;
    pair_sum  = {1'b0, lft} + {1'b0, px};
    held_word = ((period != '0) && (phase == '0)) ? pair_sum[SAMPLE_BITS:1] : pend_px;
    tail_word = ((period != '0) && (phase_step == '0)) ? pend_px : px;
  end

  always_comb begin
    push            = '0;
    data_a          = held_word;
    phase_next      = phase;
    pend_valid_next = pend_valid;
    pend_first_next = pend_first;
    if (accept) begin
      if (!pend_valid) begin
        if (last) begin
          // row of one pixel: pass it straight through
          push.one        = 1'b1;
          push.flags_a    = '{row_last: 1'b1, burst_last: 1'b1};
          data_a          = px;
          phase_next      = '0;
        end else begin
          pend_valid_next = 1'b1;
          pend_first_next = 1'b1;
          phase_next      = ((period != '0) && (PERIOD_BITS'(1) >= period)) ?
                            '0 : PERIOD_BITS'(1);
        end
      end else if (last) begin
        // release the held word and close the row
        push.one        = 1'b1;
        push.two        = 1'b1;
        push.flags_a    = '{row_last: 1'b0, burst_last: 1'b0};
        push.flags_b    = '{row_last: 1'b1, burst_last: 1'b1};
        pend_valid_next = 1'b0;
        pend_first_next = 1'b0;
        phase_next      = '0;
      end else begin
        push.one        = 1'b1;
        push.flags_a    = '{row_last: 1'b0, burst_last: 1'b1};
        pend_first_next = 1'b0;
        phase_next      = phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      pend_valid <= 1'b0;
      pend_first <= 1'b0;
      phase      <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      pend_valid <= pend_valid_next;
      pend_first <= pend_first_next;
      phase      <= phase_next;
    end
  end

  // Shift the window on every accepted pixel that does not end a row
  always_ff @(posedge clk) begin
    if (accept && !last) begin
      left_nb <= pend_px;
      pend_px <= px;
    end
  end

  pcd_out_queue #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .data_a  (data_a),
    .data_b  (tail_word),
    .room    (room),
    .pix_out (pix_out)
  );

endmodule

`default_nettype wire

// File: rtl/pcd_checker.sv
// ----------------------------------------------------------------------------
// Periodic column destriper checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic row_last_out,
  input wire logic burst_last
);

  // a stalled result word stays offered with its flags unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_last_out) && $stable(burst_last))
    else $error("stalled result word changed");

  // a row's last word always closes its burst
  a_row_end_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_last_out |-> burst_last)
    else $error("row end word not marked as burst end");

  // the first word of a pair is followed at once by the row's last word
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !burst_last |=> out_valid && row_last_out)
    else $error("second word of a row-end pair missing");

  // nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind periodic_column_destriper_unit pcd_checker u_pcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (pix_out.valid),
  .out_ready    (pix_out.ready),
  .row_last_out (pix_out.row_last_out),
  .burst_last   (pix_out.burst_last)
);

`default_nettype wire
